// ===== hw/rtl/bcc_pkg.sv =====
// Package for the balance car cascade controller.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies; every other file imports it.
`default_nettype none

package bcc_pkg;

  // Field widths of the channels.
  localparam int TILT_W      = 17;
  localparam int RATE_W      = 20;
  localparam int COUNT_W     = 16;
  localparam int LINE_W      = 8;
  localparam int GAIN_W      = 24;
  localparam int ANGLE_W     = 17;
  localparam int LIMIT_W     = 16;
  localparam int OUT_W       = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Controller state, Q.8.
  localparam int FS_W  = 26;
  localparam int SI_W  = 23;
  localparam int Q8_SH = 8;

  // Speed filter numerator and its magnitude for the serial divide.
  localparam int NUM_W   = 29;
  localparam int MAG_W   = 28;
  localparam int REM_W   = 3;
  localparam int DIVISOR = 5;

  // Integral update sum width and clamp.
  localparam int ISUM_W    = 28;
  localparam int INTEG_MAX = 2560000;

  // Serial multiply-accumulate lanes.
  localparam int XW       = 26;
  localparam int ACC_W    = XW + 2;
  localparam int FRAC_W   = 16;
  localparam int LOW_KEEP = GAIN_W - FRAC_W;
  localparam int QW       = ACC_W + LOW_KEEP;
  localparam int OUT_MAX  = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN  = -(2 ** (OUT_W - 1));

  // Sequencer step counter.
  localparam int CNT_W = $clog2(MAG_W);

  localparam int LINE_CENTER = 64;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_BAL_PROP_GAIN  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAL_DERIV_GAIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VEL_PROP_GAIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VEL_INTEG_GAIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_KP        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_KD        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BALANCE_ANGLE  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_LIMIT     = 3'd7;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  BAL_PROP_GAIN_RST  = GAIN_W'(51200);
  localparam logic [GAIN_W-1:0]  BAL_DERIV_GAIN_RST = GAIN_W'(256);
  localparam logic [GAIN_W-1:0]  VEL_PROP_GAIN_RST  = GAIN_W'(-13312);
  localparam logic [GAIN_W-1:0]  VEL_INTEG_GAIN_RST = GAIN_W'(-67);
  localparam logic [GAIN_W-1:0]  TURN_KP_RST        = GAIN_W'(4608);
  localparam logic [GAIN_W-1:0]  TURN_KD_RST        = GAIN_W'(46);
  localparam logic [ANGLE_W-1:0] BALANCE_ANGLE_RST  = ANGLE_W'(0);
  localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST     = LIMIT_W'(20480);

  // Configuration register set.
  typedef struct packed {
    logic [GAIN_W-1:0]  bal_prop_gain;
    logic [GAIN_W-1:0]  bal_deriv_gain;
    logic [GAIN_W-1:0]  vel_prop_gain;
    logic [GAIN_W-1:0]  vel_integ_gain;
    logic [GAIN_W-1:0]  turn_kp;
    logic [GAIN_W-1:0]  turn_kd;
    logic [ANGLE_W-1:0] balance_angle;
    logic [LIMIT_W-1:0] tilt_limit;
  } cfg_t;

  // Control of one serial multiply-accumulate lane.
  typedef struct packed {
    logic load;
    logic step;
    logic last;
    logic low_en;
  } mac_ctrl_t;

  // Control of the serial divider.
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bcc_ifs.sv =====
// Channel interfaces of the balance car cascade controller.
// Sensor, result and configuration channels; widths come from bcc_pkg.
`default_nettype none

// Sensor samples, one request per control tick.
interface bcc_sensor_if import bcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [TILT_W-1:0]  tilt;
  logic signed [RATE_W-1:0]  tilt_rate;
  logic signed [COUNT_W-1:0] left_count;
  logic signed [COUNT_W-1:0] right_count;
  logic signed [COUNT_W-1:0] move_offset;
  logic        [LINE_W-1:0]  line_pos;
  logic signed [COUNT_W-1:0] yaw_rate;

  modport source (output valid, tilt, tilt_rate, left_count, right_count, move_offset,
                  line_pos, yaw_rate, input ready);
  modport sink (input valid, tilt, tilt_rate, left_count, right_count, move_offset,
                line_pos, yaw_rate, output ready);
endinterface

// Drive terms, one request per sensor request.
interface bcc_result_if import bcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] balance_out;
  logic signed [OUT_W-1:0] velocity_out;
  logic signed [OUT_W-1:0] turn_out;
  logic                    tilted_over;

  modport source (output valid, balance_out, velocity_out, turn_out, tilted_over,
                  input ready);
  modport sink (input valid, balance_out, velocity_out, turn_out, tilted_over,
                output ready);
endinterface

// Register writes.
interface bcc_cfg_if import bcc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bcc_regs.sv =====
// Configuration register file of the balance car cascade controller.
// Depends on bcc_pkg and bcc_cfg_if.
`default_nettype none

module bcc_regs import bcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bcc_cfg_if.sink   cfg,
  output cfg_t      creg
);

  // Writes are always taken; the user must write only while idle; the block does not enforce it.
  assign cfg.ready = 1'b1;

  // Register writes, truncated to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      creg.bal_prop_gain  <= BAL_PROP_GAIN_RST;
      creg.bal_deriv_gain <= BAL_DERIV_GAIN_RST;
      creg.vel_prop_gain  <= VEL_PROP_GAIN_RST;
      creg.vel_integ_gain <= VEL_INTEG_GAIN_RST;
      creg.turn_kp        <= TURN_KP_RST;
      creg.turn_kd        <= TURN_KD_RST;
      creg.balance_angle  <= BALANCE_ANGLE_RST;
      creg.tilt_limit     <= TILT_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BAL_PROP_GAIN:  creg.bal_prop_gain  <= cfg.data[GAIN_W-1:0];
        REG_BAL_DERIV_GAIN: creg.bal_deriv_gain <= cfg.data[GAIN_W-1:0];
        REG_VEL_PROP_GAIN:  creg.vel_prop_gain  <= cfg.data[GAIN_W-1:0];
        REG_VEL_INTEG_GAIN: creg.vel_integ_gain <= cfg.data[GAIN_W-1:0];
        REG_TURN_KP:        creg.turn_kp        <= cfg.data[GAIN_W-1:0];
        REG_TURN_KD:        creg.turn_kd        <= cfg.data[GAIN_W-1:0];
        REG_BALANCE_ANGLE:  creg.balance_angle  <= cfg.data[ANGLE_W-1:0];
        REG_TILT_LIMIT:     creg.tilt_limit     <= cfg.data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bcc_div5.sv =====
// Bit-serial divide by five with truncation toward zero, one quotient bit per step.
// Depends on bcc_pkg.
`default_nettype none

module bcc_div5 import bcc_pkg::*; (
  input  logic                     clk,
  input  div_ctrl_t                ctrl,
  input  logic signed [NUM_W-1:0]  num,
  output logic signed [FS_W-1:0]   quo
);

  logic [MAG_W-1:0] sh;
  logic [REM_W-1:0] rem;
  logic             neg;

  logic [NUM_W-1:0] num_mag;
  logic [REM_W:0]   trial;
  logic             ge;
  logic [MAG_W:0]   qmag;
  logic [MAG_W:0]   qsgn;

  // Magnitude of the dividend; the sign is put back at the end.
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // Restoring step: bring down one dividend bit, subtract five when it fits.
  assign trial = {rem, sh[MAG_W-1]};
  assign ge    = (trial >= (REM_W + 1)'(DIVISOR));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sh  <= num_mag[MAG_W-1:0];
      rem <= '0;
      neg <= num[NUM_W-1];
    end else if (ctrl.step) begin
      sh  <= {sh[MAG_W-2:0], ge};
      rem <= ge ? REM_W'(trial - (REM_W + 1)'(DIVISOR)) : trial[REM_W-1:0];
    end
  end

  // After the last step the shift register holds the quotient magnitude.
  assign qmag = {1'b0, sh};
  assign qsgn = neg ? (MAG_W + 1)'(-qmag) : qmag;
  assign quo  = qsgn[FS_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/bcc_mac.sv =====
// Bit-serial multiply-accumulate lane: g1*x1 + g2*x2, one gain bit per step,
// scaled down by 2^16 with truncation toward zero and saturated. Depends on bcc_pkg.
`default_nettype none

module bcc_mac import bcc_pkg::*; (
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic [GAIN_W-1:0]        g1,
  input  logic [GAIN_W-1:0]        g2,
  input  logic signed [XW-1:0]     x1,
  input  logic signed [XW-1:0]     x2,
  output logic signed [OUT_W-1:0]  term
);

  logic [GAIN_W-1:0]       g1s;
  logic [GAIN_W-1:0]       g2s;
  logic signed [XW-1:0]    x1r;
  logic signed [XW-1:0]    x2r;
  logic signed [ACC_W-1:0] acc;
  logic [LOW_KEEP-1:0]     lowr;
  logic                    sticky;

  logic signed [ACC_W-1:0] sel1;
  logic signed [ACC_W-1:0] sel2;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] sum;
  logic signed [QW-1:0]    quot;
  logic signed [QW-1:0]    quot_adj;
  logic                    round_up;

  // Partial products for the current gain bit; the gain sign bit weighs negative.
  assign sel1   = g1s[0] ? ACC_W'(x1r) : '0;
  assign sel2   = g2s[0] ? ACC_W'(x2r) : '0;
  assign addend = sel1 + sel2;
  assign sum    = ctrl.last ? (acc - addend) : (acc + addend);

  // The accumulator shifts right; bits that drop out keep the low product bits.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      g1s    <= g1;
      g2s    <= g2;
      x1r    <= x1;
      x2r    <= x2;
      acc    <= '0;
      lowr   <= '0;
      sticky <= 1'b0;
    end else if (ctrl.step) begin
      g1s  <= g1s >> 1;
      g2s  <= g2s >> 1;
      acc  <= sum >>> 1;
      lowr <= {sum[0], lowr[LOW_KEEP-1:1]};
      if (ctrl.low_en) begin
        sticky <= sticky | sum[0];
      end
    end
  end

  // Floor of the product over 2^16, moved up by one for a negative inexact result.
  assign quot     = $signed({acc, lowr});
  assign round_up = acc[ACC_W-1] & sticky;
  assign quot_adj = quot + QW'(round_up);

  // Saturate to the output width.
  always_comb begin
    if (quot_adj > QW'(OUT_MAX)) begin
      term = OUT_W'(OUT_MAX);
    end else if (quot_adj < QW'(OUT_MIN)) begin
      term = OUT_W'(OUT_MIN);
    end else begin
      term = quot_adj[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/balance_car_cascade_controller.sv =====
// Balance car cascade controller: balance PD, velocity PI and turn PD per control tick.
// Depends on bcc_pkg, bcc_ifs, bcc_regs, bcc_div5 and bcc_mac.
//
// Channels: the sensor channel takes one request per tick (tilt, gyro rate, wheel
// counts, movement offset, line position, yaw rate); the result channel returns one
// request with the three drive terms and the tilt-shutdown flag. The cfg channel
// writes gain, balance angle and limit registers and is always ready; write it only while idle.
//
// Sequence: a request is taken only in idle, so the next one waits until the last result
// is loaded. The speed filter divides by five one bit per cycle, the S_FS and S_INTEG
// states update the filter and integral state, three serial multiply lanes then walk
// the 24 gain bits in parallel, and the S_FIN state loads the output register.
//
// Reset clears the filtered speed and the speed integral and loads the default gains, balance angle and tilt limit.
// The result sits in an output register: a new sensor request is accepted while it
// waits, and if the receiver still stalls when the next result is done, the block
// holds that result until the output register frees.
`default_nettype none

module balance_car_cascade_controller import bcc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bcc_cfg_if.sink      cfg,
  bcc_sensor_if.sink   sensor,
  bcc_result_if.source result
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_FS    = 3'd2;
  localparam logic [2:0] S_INTEG = 3'd3;
  localparam logic [2:0] S_MAC   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(GAIN_W - 1);
  localparam logic [CNT_W-1:0] LOW_END  = CNT_W'(FRAC_W);

  localparam logic signed [ISUM_W-1:0] ISUM_HI = ISUM_W'(INTEG_MAX);
  localparam logic signed [ISUM_W-1:0] ISUM_LO = ISUM_W'(-INTEG_MAX);
  localparam logic signed [SI_W-1:0]   SI_HI   = SI_W'(INTEG_MAX);
  localparam logic signed [SI_W-1:0]   SI_LO   = SI_W'(-INTEG_MAX);

  cfg_t creg;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [CNT_W-1:0]           cnt;
  logic signed [FS_W-1:0]     fs;
  logic signed [SI_W-1:0]     si;
  logic signed [COUNT_W-1:0]  move_q;
  logic                       over_q;
  logic                       res_valid;
  logic signed [OUT_W-1:0]    res_balance;
  logic signed [OUT_W-1:0]    res_velocity;
  logic signed [OUT_W-1:0]    res_turn;
  logic                       res_tilted;

  logic                       take;
  logic                       fin_load;
  logic signed [NUM_W-1:0]    fs_x;
  logic signed [NUM_W-1:0]    wheel_sum;
  logic signed [NUM_W-1:0]    num;
  logic signed [FS_W-1:0]     div_quo;
  logic signed [TILT_W:0]     tilt_x;
  logic [TILT_W:0]            tilt_mag;
  logic                       over;
  logic signed [TILT_W:0]     angle_err;
  logic signed [LINE_W:0]     line_err;
  logic signed [COUNT_W:0]    yaw_neg;
  logic signed [ISUM_W-1:0]   isum;
  logic signed [SI_W-1:0]     si_clamp;
  logic signed [XW-1:0]       bal_x1;
  logic signed [XW-1:0]       bal_x2;
  logic signed [XW-1:0]       turn_x1;
  logic signed [XW-1:0]       turn_x2;
  logic signed [XW-1:0]       vel_x2;
  logic signed [OUT_W-1:0]    bal_term;
  logic signed [OUT_W-1:0]    vel_term;
  logic signed [OUT_W-1:0]    turn_term;
  div_ctrl_t                  div_ctrl;
  mac_ctrl_t                  bal_ctrl;
  mac_ctrl_t                  vel_ctrl;
  mac_ctrl_t                  turn_ctrl;

  bcc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .creg (creg)
  );

  // Handshakes.
  assign sensor.ready = (state == S_IDLE);
  assign take         = sensor.valid && sensor.ready;
  assign fin_load     = (state == S_FIN) && (!res_valid || result.ready);

  // Speed filter numerator: 4*fs + 256*(left + right).
  assign fs_x      = NUM_W'(fs);
  assign wheel_sum = NUM_W'(sensor.left_count) + NUM_W'(sensor.right_count);
  assign num       = (fs_x <<< 2) + (wheel_sum <<< Q8_SH);

  // Tilt-over test on the raw tilt.
  assign tilt_x   = (TILT_W + 1)'(sensor.tilt);
  assign tilt_mag = tilt_x[TILT_W] ? (TILT_W + 1)'(-tilt_x) : (TILT_W + 1)'(tilt_x);
  assign over     = (tilt_mag > (TILT_W + 1)'(creg.tilt_limit));

  // Lane operands for the balance and turn terms. The turn term is negated by
  // feeding the negated line error and yaw, both pre-scaled by 256.
  assign angle_err = (TILT_W + 1)'(sensor.tilt) - (TILT_W + 1)'($signed(creg.balance_angle));
  assign line_err  = (LINE_W + 1)'(LINE_CENTER) - $signed({1'b0, sensor.line_pos});
  assign yaw_neg   = -((COUNT_W + 1)'(sensor.yaw_rate));
  assign bal_x1    = XW'(angle_err);
  assign bal_x2    = XW'(sensor.tilt_rate);
  assign turn_x1   = XW'(line_err) <<< Q8_SH;
  assign turn_x2   = XW'(yaw_neg) <<< Q8_SH;

  // Integral update with clamp.
  assign isum = ISUM_W'(si) + ISUM_W'(fs) - (ISUM_W'(move_q) <<< Q8_SH);
  always_comb begin
    if (isum > ISUM_HI) begin
      si_clamp = SI_HI;
    end else if (isum < ISUM_LO) begin
      si_clamp = SI_LO;
    end else begin
      si_clamp = isum[SI_W-1:0];
    end
  end
  assign vel_x2 = XW'(si_clamp);

  // Unit controls.
  assign div_ctrl.load = take;
  assign div_ctrl.step = (state == S_DIV);

  assign bal_ctrl.load    = take;
  assign bal_ctrl.step    = (state == S_MAC);
  assign bal_ctrl.last    = (cnt == MAC_LAST);
  assign bal_ctrl.low_en  = (cnt < LOW_END);
  assign turn_ctrl        = bal_ctrl;
  assign vel_ctrl.load    = (state == S_INTEG);
  assign vel_ctrl.step    = bal_ctrl.step;
  assign vel_ctrl.last    = bal_ctrl.last;
  assign vel_ctrl.low_en  = bal_ctrl.low_en;

  bcc_div5 u_div (
    .clk  (clk),
    .ctrl (div_ctrl),
    .num  (num),
    .quo  (div_quo)
  );

  bcc_mac u_bal (
    .clk  (clk),
    .ctrl (bal_ctrl),
    .g1   (creg.bal_prop_gain),
    .g2   (creg.bal_deriv_gain),
    .x1   (bal_x1),
    .x2   (bal_x2),
    .term (bal_term)
  );

  bcc_mac u_vel (
    .clk  (clk),
    .ctrl (vel_ctrl),
    .g1   (creg.vel_prop_gain),
    .g2   (creg.vel_integ_gain),
    .x1   (fs),
    .x2   (vel_x2),
    .term (vel_term)
  );

  bcc_mac u_turn (
    .clk  (clk),
    .ctrl (turn_ctrl),
    .g1   (creg.turn_kp),
    .g2   (creg.turn_kd),
    .x1   (turn_x1),
    .x2   (turn_x2),
    .term (turn_term)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (take) state_next = S_DIV;
      S_DIV:   if (cnt == DIV_LAST) state_next = S_FS;
      S_FS:    state_next = S_INTEG;
      S_INTEG: state_next = S_MAC;
      S_MAC:   if (cnt == MAC_LAST) state_next = S_FIN;
      S_FIN:   if (fin_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer, step counter and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      fs    <= '0;
      si    <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV || state == S_MAC) begin
        cnt <= (cnt == DIV_LAST || state_next != state) ? '0 : cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (state == S_FS) begin
        fs <= div_quo;
      end
      if (state == S_INTEG) begin
        si <= over_q ? '0 : si_clamp;
      end
    end
  end

  // Per-request values held while the request is worked on.
  always_ff @(posedge clk) begin
    if (take) begin
      move_q <= sensor.move_offset;
      over_q <= over;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      res_balance  <= bal_term;
      res_velocity <= vel_term;
      res_turn     <= turn_term;
      res_tilted   <= over_q;
    end
  end

  assign result.valid        = res_valid;
  assign result.balance_out  = res_balance;
  assign result.velocity_out = res_velocity;
  assign result.turn_out     = res_turn;
  assign result.tilted_over  = res_tilted;

  // An accepted request always starts the divide.
  a_take_starts_div: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == S_DIV))
    else $error("accepted request did not start the divide");

  // The speed integral never leaves its clamp range.
  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (si <= SI_HI) && (si >= SI_LO))
    else $error("speed integral outside clamp range");

  // A tilted-over request clears the integral after its update.
  a_tilt_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_INTEG) && over_q) |=> (si == '0))
    else $error("speed integral not cleared after tilt-over");

  // The multiply phase ends on its last gain-bit step.
  a_mac_length: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MAC) && (cnt == MAC_LAST)) |=> (state == S_FIN))
    else $error("multiply phase did not end on its last step");

endmodule

`default_nettype wire
